>>> rtl/antialiased_line_rasterizer_top_assert.svh
// Assertion macros shared by the rasterizer RTL.
`ifndef ANTIALIASED_LINE_RASTERIZER_TOP_ASSERT_SVH
`define ANTIALIASED_LINE_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication
`define ALR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ALR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/alr_pkg.sv
package alr_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int PIX_W    = COORD_BITS + 1;
    localparam int ACC_W    = COORD_BITS + FRAC_BITS + 2;
    localparam int SLOPE_W  = FRAC_BITS + 2;
    localparam int WGT_W    = FRAC_BITS + 1;
    localparam int NUM_W    = COORD_BITS + FRAC_BITS;
    localparam int DCNT_W   = $clog2(NUM_W + 1);
    localparam int COLOR_W  = 24;
    localparam int COV_W    = 8;
    localparam int N_CHAN   = 3;
    localparam int CHAN_W   = 2;

    localparam int MUL_A_W  = (WGT_W > 16) ? WGT_W : 16;
    localparam int MUL_B_W  = 16;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    // x / 255 == (x * 0x8081) >> 23 for every 16-bit x
    localparam logic [MUL_B_W-1:0] RECIP_255   = 16'h8081;
    localparam int                 RECIP_SHIFT = 23;
    localparam logic [15:0]        ROUND_127   = 16'd127;
    localparam logic [MUL_B_W-1:0] COV_SCALE   = 16'd255;

    localparam logic [WGT_W-1:0] ONE_WGT  = WGT_W'(1) << FRAC_BITS;
    localparam logic [WGT_W-1:0] HALF_WGT = WGT_W'(1) << (FRAC_BITS - 1);

    localparam int S_TDATA_W = ((4 * COORD_BITS + COLOR_W + 7) / 8) * 8;
    localparam int M_USED_W  = 2 * PIX_W + COV_W + COLOR_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_GO,
        ST_SHADE,
        ST_PUSH
    } alr_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FAR,
        PH_INNER
    } alr_phase_t;

    typedef enum logic [1:0] {
        SH_IDLE,
        SH_COV,
        SH_CMUL,
        SH_CDIV
    } shd_step_t;

    typedef struct packed {
        logic                  start;
        logic [NUM_W-1:0]      num;
        logic [COORD_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [WGT_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [WGT_W-1:0]   weight;
        logic [COLOR_W-1:0] color;
    } shd_req_t;

    typedef struct packed {
        logic               done;
        logic [COV_W-1:0]   cov;
        logic [COLOR_W-1:0] color;
    } shd_rsp_t;

endpackage

>>> rtl/alr_div.sv
// Restoring divider, one quotient bit per cycle.
module alr_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  alr_pkg::div_req_t req,
    output alr_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [alr_pkg::DCNT_W-1:0]     cnt_reg, cnt_next;
    logic [alr_pkg::NUM_W-1:0]      num_reg, num_next;
    logic [alr_pkg::COORD_BITS-1:0] rem_reg, rem_next;
    logic [alr_pkg::COORD_BITS-1:0] den_reg, den_next;
    logic [alr_pkg::COORD_BITS:0]   trial;
    logic [alr_pkg::COORD_BITS:0]   diff;
    logic                           qbit;

    always_comb begin
        trial = {rem_reg, num_reg[alr_pkg::NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        qbit  = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = alr_pkg::DCNT_W'(alr_pkg::NUM_W);
            num_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end else if (busy_reg) begin
            // remainder stays below den, so it fits COORD_BITS
            rem_next = qbit ? diff[alr_pkg::COORD_BITS-1:0] : trial[alr_pkg::COORD_BITS-1:0];
            num_next = {num_reg[alr_pkg::NUM_W-2:0], qbit};
            cnt_next = cnt_reg - alr_pkg::DCNT_W'(1);
            if (cnt_reg == alr_pkg::DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg[alr_pkg::WGT_W-1:0];

endmodule

>>> rtl/alr_shade.sv
// Coverage and color scaling on one shared multiplier:
// weight*255, then per channel c*cov+127 followed by the /255 reciprocal.
module alr_shade (
    input  logic              aclk,
    input  logic              aresetn,
    input  alr_pkg::shd_req_t req,
    output alr_pkg::shd_rsp_t rsp
);

    alr_pkg::shd_step_t             step_reg, step_next;
    logic                           done_reg, done_next;
    logic [alr_pkg::CHAN_W-1:0]     chan_reg, chan_next;
    logic [alr_pkg::WGT_W-1:0]      wgt_reg, wgt_next;
    logic [alr_pkg::COLOR_W-1:0]    src_reg, src_next;
    logic [alr_pkg::COV_W-1:0]      cov_reg, cov_next;
    logic [15:0]                    x_reg, x_next;
    logic [alr_pkg::COLOR_W-1:0]    col_reg, col_next;

    logic [alr_pkg::MUL_A_W-1:0]    mul_a;
    logic [alr_pkg::MUL_B_W-1:0]    mul_b;
    logic [alr_pkg::MUL_P_W-1:0]    prod;
    logic [alr_pkg::MUL_P_W-1:0]    cov_sum;
    logic [alr_pkg::MUL_P_W-1:0]    cov_sh;
    logic [7:0]                     chan_byte;
    logic [7:0]                     quot;

    always_comb begin
        case (chan_reg)
            2'd0:    chan_byte = src_reg[7:0];
            2'd1:    chan_byte = src_reg[15:8];
            default: chan_byte = src_reg[23:16];
        endcase

        case (step_reg)
            alr_pkg::SH_COV: begin
                mul_a = alr_pkg::MUL_A_W'(wgt_reg);
                mul_b = alr_pkg::COV_SCALE;
            end
            alr_pkg::SH_CMUL: begin
                mul_a = alr_pkg::MUL_A_W'(cov_reg);
                mul_b = alr_pkg::MUL_B_W'(chan_byte);
            end
            alr_pkg::SH_CDIV: begin
                mul_a = alr_pkg::MUL_A_W'(x_reg);
                mul_b = alr_pkg::RECIP_255;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        prod    = alr_pkg::MUL_P_W'(mul_a) * alr_pkg::MUL_P_W'(mul_b);
        cov_sum = prod + alr_pkg::MUL_P_W'(alr_pkg::HALF_WGT);
        cov_sh  = cov_sum >> alr_pkg::FRAC_BITS;
        quot    = prod[alr_pkg::RECIP_SHIFT +: 8];

        step_next = step_reg;
        done_next = 1'b0;
        chan_next = chan_reg;
        wgt_next  = wgt_reg;
        src_next  = src_reg;
        cov_next  = cov_reg;
        x_next    = x_reg;
        col_next  = col_reg;

        if (req.start) begin
            step_next = alr_pkg::SH_COV;
            wgt_next  = req.weight;
            src_next  = req.color;
        end else begin
            case (step_reg)
                alr_pkg::SH_COV: begin
                    cov_next  = (cov_sh > alr_pkg::MUL_P_W'(255)) ? 8'hFF : cov_sh[7:0];
                    chan_next = '0;
                    step_next = alr_pkg::SH_CMUL;
                end
                alr_pkg::SH_CMUL: begin
                    x_next    = prod[15:0] + alr_pkg::ROUND_127;
                    step_next = alr_pkg::SH_CDIV;
                end
                alr_pkg::SH_CDIV: begin
                    case (chan_reg)
                        2'd0:    col_next[7:0]   = quot;
                        2'd1:    col_next[15:8]  = quot;
                        default: col_next[23:16] = quot;
                    endcase
                    if (chan_reg == alr_pkg::CHAN_W'(alr_pkg::N_CHAN - 1)) begin
                        step_next = alr_pkg::SH_IDLE;
                        done_next = 1'b1;
                    end else begin
                        chan_next = chan_reg + alr_pkg::CHAN_W'(1);
                        step_next = alr_pkg::SH_CMUL;
                    end
                end
                default: step_next = alr_pkg::SH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= alr_pkg::SH_IDLE;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        chan_reg <= chan_next;
        wgt_reg  <= wgt_next;
        src_reg  <= src_next;
        cov_reg  <= cov_next;
        x_reg    <= x_next;
        col_reg  <= col_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.cov   = cov_reg;
    assign rsp.color = col_reg;

endmodule

>>> rtl/antialiased_line_rasterizer_top.sv
// Channel  Dir  tdata (low bit up)                                tuser / tlast
// s_       in   x_start, y_start, x_end, y_end, line_color         tuser = cmd
// m_       out  pixel_x, pixel_y, coverage, pixel_color, zero pad  tuser = line_done,
//                                                                  tlast = run_last
// Start word: taken, then the divide state (the divider is not started if zero length),
// then two pixels. Each pixel: issue, 7 passes of the shared multiplier, done and handoff.
// A step word yields two pixels, or none with no line running.
// Reset is synchronous and clears the sequencers and the output valid; no clearing pass.
// m_tready low holds the pixel in the output register; the next pixel is shaded
// meanwhile and waits for the register to empty. s_tready is high only when idle.

`include "antialiased_line_rasterizer_top_assert.svh"

module antialiased_line_rasterizer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_start, y_start, x_end, y_end, line_color
    input  logic [alr_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_x, pixel_y, coverage, pixel_color, zero pad
    output logic [alr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    // line_done
    output logic                            m_tuser
);

    localparam int CB = alr_pkg::COORD_BITS;
    localparam int PW = alr_pkg::PIX_W;

    alr_pkg::alr_state_t            state_reg, state_next;
    alr_pkg::alr_phase_t            phase_reg, phase_next;
    logic                           m_valid_reg, m_valid_next;

    logic                           steep_reg, steep_next;
    logic                           neg_reg, neg_next;
    logic                           degen_reg, degen_next;
    logic [CB-1:0]                  start_maj_reg, start_maj_next;
    logic [CB-1:0]                  start_min_reg, start_min_next;
    logic [PW-1:0]                  far_maj_reg, far_maj_next;
    logic [PW-1:0]                  far_min_reg, far_min_next;
    logic [alr_pkg::COLOR_W-1:0]    color_reg, color_next;
    logic [PW-1:0]                  major_pos_reg, major_pos_next;
    logic [PW-1:0]                  major_last_reg, major_last_next;
    logic [alr_pkg::ACC_W-1:0]      minor_acc_reg, minor_acc_next;
    logic [alr_pkg::SLOPE_W-1:0]    slope_reg, slope_next;
    logic [PW-1:0]                  pair_maj_reg, pair_maj_next;
    logic [PW-1:0]                  pair_mnr_reg, pair_mnr_next;
    logic [alr_pkg::WGT_W-1:0]      pair_w0_reg, pair_w0_next;
    logic [alr_pkg::WGT_W-1:0]      pair_w1_reg, pair_w1_next;
    logic                           pair_done_reg, pair_done_next;
    logic                           pix_k_reg, pix_k_next;

    logic [PW-1:0]                  out_x_reg, out_x_next;
    logic [PW-1:0]                  out_y_reg, out_y_next;
    logic [alr_pkg::COV_W-1:0]      out_cov_reg, out_cov_next;
    logic [alr_pkg::COLOR_W-1:0]    out_color_reg, out_color_next;
    logic                           out_last_reg, out_last_next;
    logic                           out_done_reg, out_done_next;

    alr_pkg::div_req_t              div_req;
    alr_pkg::div_rsp_t              div_rsp;
    alr_pkg::shd_req_t              shd_req;
    alr_pkg::shd_rsp_t              shd_rsp;

    // start word decode
    logic [CB-1:0]                  ax, ay, bx, by;
    logic [alr_pkg::COLOR_W-1:0]    in_color;
    logic [CB:0]                    dx, dy, adx_full, ady_full, dmin, admin_full;
    logic [CB-1:0]                  adx, ady;
    logic                           steep_in, swap;
    logic [CB-1:0]                  amaj0, amin0, bmaj0, bmin0;
    logic [CB-1:0]                  amaj, amin, bmaj, bmin, dmaj;

    // per-step values
    logic                           far_done;
    logic [PW-1:0]                  floor_mnr;
    logic [alr_pkg::FRAC_BITS-1:0]  frac_mnr;
    logic [PW-1:0]                  major_inc;
    logic                           inner_done;
    logic [alr_pkg::SLOPE_W-1:0]    quot_ext, slope_v;
    logic [PW-1:0]                  pix_mnr;

    alr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    alr_shade u_shade (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (shd_req),
        .rsp     (shd_rsp)
    );

    always_comb begin
        ax       = s_tdata[0 +: CB];
        ay       = s_tdata[CB +: CB];
        bx       = s_tdata[2*CB +: CB];
        by       = s_tdata[3*CB +: CB];
        in_color = s_tdata[4*CB +: alr_pkg::COLOR_W];

        dx       = {1'b0, bx} - {1'b0, ax};
        dy       = {1'b0, by} - {1'b0, ay};
        adx_full = dx[CB] ? ((CB+1)'(0) - dx) : dx;
        ady_full = dy[CB] ? ((CB+1)'(0) - dy) : dy;
        adx      = adx_full[CB-1:0];
        ady      = ady_full[CB-1:0];
        // equal spans take y as the major axis
        steep_in = !(adx > ady);

        amaj0 = steep_in ? ay : ax;
        amin0 = steep_in ? ax : ay;
        bmaj0 = steep_in ? by : bx;
        bmin0 = steep_in ? bx : by;
        swap  = (bmaj0 < amaj0);
        amaj  = swap ? bmaj0 : amaj0;
        amin  = swap ? bmin0 : amin0;
        bmaj  = swap ? amaj0 : bmaj0;
        bmin  = swap ? amin0 : bmin0;

        dmaj       = bmaj - amaj;
        dmin       = {1'b0, bmin} - {1'b0, amin};
        admin_full = dmin[CB] ? ((CB+1)'(0) - dmin) : dmin;

        far_done   = (major_pos_reg >= major_last_reg);
        floor_mnr  = minor_acc_reg[alr_pkg::FRAC_BITS +: PW];
        frac_mnr   = minor_acc_reg[alr_pkg::FRAC_BITS-1:0];
        major_inc  = major_pos_reg + PW'(1);
        inner_done = (major_inc >= major_last_reg);

        quot_ext = {1'b0, div_rsp.quot};
        if (degen_reg) begin
            slope_v = '0;
        end else if (neg_reg) begin
            slope_v = alr_pkg::SLOPE_W'(0) - quot_ext;
        end else begin
            slope_v = quot_ext;
        end

        pix_mnr = pair_mnr_reg + PW'(pix_k_reg);

        div_req.start = 1'b0;
        div_req.num   = {admin_full[CB-1:0], {alr_pkg::FRAC_BITS{1'b0}}};
        div_req.den   = dmaj;

        shd_req.start  = 1'b0;
        shd_req.weight = pix_k_reg ? pair_w1_reg : pair_w0_reg;
        shd_req.color  = color_reg;

        state_next      = state_reg;
        phase_next      = phase_reg;
        m_valid_next    = m_valid_reg;
        steep_next      = steep_reg;
        neg_next        = neg_reg;
        degen_next      = degen_reg;
        start_maj_next  = start_maj_reg;
        start_min_next  = start_min_reg;
        far_maj_next    = far_maj_reg;
        far_min_next    = far_min_reg;
        color_next      = color_reg;
        major_pos_next  = major_pos_reg;
        major_last_next = major_last_reg;
        minor_acc_next  = minor_acc_reg;
        slope_next      = slope_reg;
        pair_maj_next   = pair_maj_reg;
        pair_mnr_next   = pair_mnr_reg;
        pair_w0_next    = pair_w0_reg;
        pair_w1_next    = pair_w1_reg;
        pair_done_next  = pair_done_reg;
        pix_k_next      = pix_k_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_cov_next    = out_cov_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            alr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser) begin
                        steep_next     = steep_in;
                        neg_next       = dmin[CB];
                        degen_next     = (dmaj == '0);
                        start_maj_next = amaj;
                        start_min_next = amin;
                        far_maj_next   = {1'b0, bmaj};
                        far_min_next   = {1'b0, bmin};
                        color_next     = in_color;
                        div_req.start  = (dmaj != '0);
                        state_next     = alr_pkg::ST_DIV;
                    end else if (phase_reg == alr_pkg::PH_FAR) begin
                        pair_maj_next  = far_maj_reg;
                        pair_mnr_next  = far_min_reg;
                        pair_w0_next   = alr_pkg::HALF_WGT;
                        pair_w1_next   = '0;
                        pair_done_next = far_done;
                        phase_next     = far_done ? alr_pkg::PH_IDLE : alr_pkg::PH_INNER;
                        pix_k_next     = 1'b0;
                        state_next     = alr_pkg::ST_GO;
                    end else if (phase_reg == alr_pkg::PH_INNER) begin
                        pair_maj_next  = major_pos_reg;
                        pair_mnr_next  = floor_mnr;
                        pair_w0_next   = alr_pkg::ONE_WGT - {1'b0, frac_mnr};
                        pair_w1_next   = {1'b0, frac_mnr};
                        pair_done_next = inner_done;
                        major_pos_next = major_inc;
                        minor_acc_next = minor_acc_reg
                                         + {{(alr_pkg::ACC_W-alr_pkg::SLOPE_W)
                                             {slope_reg[alr_pkg::SLOPE_W-1]}}, slope_reg};
                        if (inner_done) begin
                            phase_next = alr_pkg::PH_IDLE;
                        end
                        pix_k_next     = 1'b0;
                        state_next     = alr_pkg::ST_GO;
                    end
                end
            end
            alr_pkg::ST_DIV: begin
                if (degen_reg || div_rsp.done) begin
                    slope_next      = slope_v;
                    major_pos_next  = {1'b0, start_maj_reg} + PW'(1);
                    major_last_next = far_maj_reg;
                    minor_acc_next  = {2'b00, start_min_reg, {alr_pkg::FRAC_BITS{1'b0}}}
                                      + {{(alr_pkg::ACC_W-alr_pkg::SLOPE_W)
                                          {slope_v[alr_pkg::SLOPE_W-1]}}, slope_v};
                    phase_next      = alr_pkg::PH_FAR;
                    pair_maj_next   = {1'b0, start_maj_reg};
                    pair_mnr_next   = {1'b0, start_min_reg};
                    pair_w0_next    = alr_pkg::HALF_WGT;
                    pair_w1_next    = '0;
                    pair_done_next  = 1'b0;
                    pix_k_next      = 1'b0;
                    state_next      = alr_pkg::ST_GO;
                end
            end
            alr_pkg::ST_GO: begin
                shd_req.start = 1'b1;
                state_next    = alr_pkg::ST_SHADE;
            end
            alr_pkg::ST_SHADE: begin
                if (shd_rsp.done) begin
                    state_next = alr_pkg::ST_PUSH;
                end
            end
            alr_pkg::ST_PUSH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    out_x_next     = steep_reg ? pix_mnr : pair_maj_reg;
                    out_y_next     = steep_reg ? pair_maj_reg : pix_mnr;
                    out_cov_next   = shd_rsp.cov;
                    out_color_next = shd_rsp.color;
                    out_last_next  = pix_k_reg;
                    out_done_next  = pix_k_reg & pair_done_reg;
                    if (pix_k_reg) begin
                        state_next = alr_pkg::ST_IDLE;
                    end else begin
                        pix_k_next = 1'b1;
                        state_next = alr_pkg::ST_GO;
                    end
                end
            end
            default: state_next = alr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= alr_pkg::ST_IDLE;
            phase_reg   <= alr_pkg::PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        steep_reg      <= steep_next;
        neg_reg        <= neg_next;
        degen_reg      <= degen_next;
        start_maj_reg  <= start_maj_next;
        start_min_reg  <= start_min_next;
        far_maj_reg    <= far_maj_next;
        far_min_reg    <= far_min_next;
        color_reg      <= color_next;
        major_pos_reg  <= major_pos_next;
        major_last_reg <= major_last_next;
        minor_acc_reg  <= minor_acc_next;
        slope_reg      <= slope_next;
        pair_maj_reg   <= pair_maj_next;
        pair_mnr_reg   <= pair_mnr_next;
        pair_w0_reg    <= pair_w0_next;
        pair_w1_reg    <= pair_w1_next;
        pair_done_reg  <= pair_done_next;
        pix_k_reg      <= pix_k_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_cov_reg    <= out_cov_next;
        out_color_reg  <= out_color_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
    end

    assign s_tready = (state_reg == alr_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = alr_pkg::M_TDATA_W'({out_color_reg, out_cov_reg, out_y_reg, out_x_reg});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

    `ALR_ASSERT_NOW(a_div_done_in_div, aclk, aresetn, div_rsp.done, state_reg == alr_pkg::ST_DIV, "divider finished outside the divide state")
    `ALR_ASSERT_NOW(a_shade_done_in_shade, aclk, aresetn, shd_rsp.done, state_reg == alr_pkg::ST_SHADE, "shade finished outside the shade state")
    `ALR_ASSERT_NOW(a_done_on_second, aclk, aresetn, m_tvalid && m_tuser, m_tlast, "line end flagged on the first pixel of a pair")
    `ALR_ASSERT_NEXT(a_push_waits, aclk, aresetn, state_reg == alr_pkg::ST_PUSH && m_valid_reg && !m_tready, state_reg == alr_pkg::ST_PUSH, "pixel handoff left while the output register was full")

endmodule
